FILE: src/mdrs_pkg.sv
// Shared types and constants of the motor drive run/stop sequencer.
package mdrs_pkg;

    // Event codes carried in the input tuser field
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_ESTOP = 2'd1;
    localparam logic [1:0] OP_TRIP  = 2'd2;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_DC_BRAKE_DELAY      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BRAKE_RELEASE_DELAY = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BRAKE_HOLD_DELAY    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MOTOR_MOVE_DELAY    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TORQUE_DECAY_TIME   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_CLOSED_LOOP_MODE    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_SOFTCHARGE_HOLD     = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_PM_VECTOR_MODE      = 3'd7;

    // Power-up delay: regulator reset fires at INIT_TICKS >> INIT_SHIFT
    localparam int INIT_SHIFT = 3;

    // Bit positions in the status flag word
    localparam int FLAG_W     = 7;
    localparam int F_BRAKE    = 0;
    localparam int F_INHIBIT  = 1;
    localparam int F_RELAY    = 2;
    localparam int F_STOPPING = 3;
    localparam int F_DECAY    = 4;
    localparam int F_SERVO    = 5;
    localparam int F_SCTEST   = 6;

    typedef enum logic [2:0] {
        PH_INIT   = 3'd0,
        PH_ACTIVE = 3'd1,
        PH_STOP   = 3'd2,
        PH_TRIP   = 3'd3,
        PH_CHECK  = 3'd4,
        PH_TUNE   = 3'd5,
        PH_NONE   = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        LINK_NONE       = 2'd0,
        LINK_CONNECT    = 2'd1,
        LINK_DISCONNECT = 2'd2
    } link_t;

    // Mode bits from the configuration registers
    typedef struct packed {
        logic closed_loop;
        logic softcharge_hold;
        logic pm_vector;
    } mode_t;

    // One input item
    typedef struct packed {
        logic [1:0] op;
        logic       ref_speed_nonzero;
        logic       desired_speed_nonzero;
        logic       drive_enabled;
        logic       motor_connected;
        logic       brake_open_allowed;
        logic       short_check_done;
        logic       any_fault;
        logic       undervoltage;
        logic       tune_requested;
    } item_t;

    // One result item
    typedef struct packed {
        phase_t drive_phase;
        logic   brake_open;
        logic   output_inhibit;
        logic   charge_relay_closed;
        logic   stopping;
        logic   torque_decay_on;
        logic   zero_servo_on;
        logic   short_test_active;
        link_t  motor_link_cmd;
        logic   regulator_reset;
        logic   ready_for_brake;
        logic   clear_tune_request;
    } res_t;

endpackage

FILE: src/mdrs_cfg.sv
// Configuration register file of the run/stop sequencer.
module mdrs_cfg #(
    parameter int DELAY_WIDTH = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic [mdrs_pkg::CFG_INDEX_W-1:0]   wr_index,
    input  logic [DELAY_WIDTH-1:0]             wr_data,
    output logic [DELAY_WIDTH-1:0]             dc_brake_delay,
    output logic [DELAY_WIDTH-1:0]             brake_release_delay,
    output logic [DELAY_WIDTH-1:0]             brake_hold_delay,
    output logic [DELAY_WIDTH-1:0]             motor_move_delay,
    output logic [DELAY_WIDTH-1:0]             torque_decay_time,
    output mdrs_pkg::mode_t                    mode,
    output logic                               relay_clr
);
    import mdrs_pkg::*;

    logic [DELAY_WIDTH-1:0] dc_brake_reg;
    logic [DELAY_WIDTH-1:0] release_reg;
    logic [DELAY_WIDTH-1:0] hold_reg;
    logic [DELAY_WIDTH-1:0] move_reg;
    logic [DELAY_WIDTH-1:0] decay_reg;
    mode_t                  mode_reg;

    // Decode writes into the register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dc_brake_reg <= '0;
            release_reg  <= '0;
            hold_reg     <= '0;
            move_reg     <= '0;
            decay_reg    <= '0;
            mode_reg     <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_DC_BRAKE_DELAY:      dc_brake_reg             <= wr_data;
                REG_BRAKE_RELEASE_DELAY: release_reg              <= wr_data;
                REG_BRAKE_HOLD_DELAY:    hold_reg                 <= wr_data;
                REG_MOTOR_MOVE_DELAY:    move_reg                 <= wr_data;
                REG_TORQUE_DECAY_TIME:   decay_reg                <= wr_data;
                REG_CLOSED_LOOP_MODE:    mode_reg.closed_loop     <= wr_data[0];
                REG_SOFTCHARGE_HOLD:     mode_reg.softcharge_hold <= wr_data[0];
                REG_PM_VECTOR_MODE:      mode_reg.pm_vector       <= wr_data[0];
            endcase
        end
    end

    // Setting softcharge hold opens the charge relay
    assign relay_clr = wr_en && (wr_index == REG_SOFTCHARGE_HOLD) && wr_data[0];

    assign dc_brake_delay      = dc_brake_reg;
    assign brake_release_delay = release_reg;
    assign brake_hold_delay    = hold_reg;
    assign motor_move_delay    = move_reg;
    assign torque_decay_time   = decay_reg;
    assign mode                = mode_reg;

endmodule

FILE: src/mdrs_core.sv
// Phase state, sequencing counters and the per-item next-state logic.
module mdrs_core #(
    parameter int INIT_TICKS  = 3000,
    parameter int DELAY_WIDTH = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  mdrs_pkg::item_t        item,
    input  logic [DELAY_WIDTH-1:0] dc_brake_delay,
    input  logic [DELAY_WIDTH-1:0] brake_release_delay,
    input  logic [DELAY_WIDTH-1:0] brake_hold_delay,
    input  logic [DELAY_WIDTH-1:0] motor_move_delay,
    input  logic [DELAY_WIDTH-1:0] torque_decay_time,
    input  mdrs_pkg::mode_t        mode,
    input  logic                   relay_clr,
    output mdrs_pkg::res_t         res
);
    import mdrs_pkg::*;

    localparam int INIT_W    = $clog2(INIT_TICKS + 1);
    localparam int INIT_MARK = INIT_TICKS >> INIT_SHIFT;

    typedef struct packed {
        phase_t                 phase;
        logic [FLAG_W-1:0]      flags;
        logic [INIT_W-1:0]      init_cnt;
        logic [DELAY_WIDTH-1:0] release_cnt;
        logic [DELAY_WIDTH:0]   dc_cnt;
        logic [DELAY_WIDTH-1:0] hold_cnt;
        logic [DELAY_WIDTH:0]   move_cnt;
        logic [DELAY_WIDTH-1:0] decay_cnt;
    } state_t;

    typedef struct packed {
        state_t st;
        link_t  link;
        logic   reg_rst;
        logic   ready;
        logic   clr_tune;
    } work_t;

    // Phase sits in the top bits of the state word
    localparam int ST_W = $bits(state_t);

    state_t state_reg;
    state_t state_next;
    work_t  w;

    // Enter the stop phase
    function automatic work_t enter_stop(work_t a, logic des);
        work_t r;
        r = a;
        r.st.phase               = PH_STOP;
        r.st.flags[F_RELAY]      = 1'b1;
        r.st.flags[F_STOPPING]   = 1'b1;
        r.st.flags[F_SERVO]      = 1'b0;
        r.st.hold_cnt            = '0;
        r.st.move_cnt            = '0;
        if (des)
        begin
            r.st.flags[F_INHIBIT] = 1'b1;
            r.st.flags[F_BRAKE]   = 1'b0;
            r.st.flags[F_DECAY]   = 1'b0;
            r.link                = LINK_DISCONNECT;
            r.reg_rst             = 1'b1;
        end
        else
        begin
            r.st.dc_cnt      = '0;
            r.st.release_cnt = '0;
            r.st.decay_cnt   = '0;
        end
        return r;
    endfunction

    // Enter the active phase; a low enable runs the stop entry first
    function automatic work_t enter_active(work_t a, logic en, logic des);
        work_t r;
        r = a;
        r.st.flags[F_DECAY] = 1'b0;
        if (!en)
            r = enter_stop(r, des);
        r.st.flags[F_STOPPING] = 1'b1;
        r.st.phase             = PH_ACTIVE;
        r.st.flags[F_INHIBIT]  = 1'b0;
        r.st.hold_cnt          = '0;
        r.st.flags[F_BRAKE]    = 1'b1;
        return r;
    endfunction

    // Enter the tune phase; a low enable runs the stop entry first
    function automatic work_t enter_tune(work_t a, logic en, logic des);
        work_t r;
        r = a;
        if (!en)
            r = enter_stop(r, des);
        r.st.flags[F_STOPPING] = 1'b0;
        r.st.flags[F_INHIBIT]  = 1'b0;
        r.link                 = LINK_CONNECT;
        r.st.phase             = PH_TUNE;
        return r;
    endfunction

    // Output shut-off at the end of a stop
    function automatic work_t finish_stop(work_t a);
        work_t r;
        r = a;
        r.st.dc_cnt            = a.st.dc_cnt + 1'b1;
        r.st.flags[F_INHIBIT]  = 1'b1;
        r.st.flags[F_STOPPING] = 1'b0;
        r.link                 = LINK_DISCONNECT;
        r.reg_rst              = 1'b1;
        return r;
    endfunction

    // Work out one item against the current state
    always_comb
    begin
        w.st       = state_reg;
        w.link     = LINK_NONE;
        w.reg_rst  = 1'b0;
        w.ready    = 1'b0;
        w.clr_tune = 1'b0;

        case (item.op)
            OP_TICK:
            begin
                if (w.st.phase == PH_NONE)
                begin
                    w.st.phase    = PH_INIT;
                    w.st.init_cnt = '0;
                end
                unique case (w.st.phase)
                    PH_INIT:
                    begin
                        if (w.st.init_cnt == INIT_W'(INIT_MARK))
                        begin
                            w.st.init_cnt         = w.st.init_cnt + 1'b1;
                            w.st.flags[F_INHIBIT] = 1'b1;
                            w.reg_rst             = 1'b1;
                        end
                        else if (w.st.init_cnt >= INIT_W'(INIT_TICKS))
                            w = enter_stop(w, item.desired_speed_nonzero);
                        else
                            w.st.init_cnt = w.st.init_cnt + 1'b1;
                    end
                    PH_ACTIVE, PH_TUNE:
                    begin
                        if (!item.drive_enabled)
                        begin
                            w = enter_stop(w, item.desired_speed_nonzero);
                            w.clr_tune = (state_reg.phase == PH_TUNE);
                        end
                        if (!item.ref_speed_nonzero && !item.desired_speed_nonzero)
                        begin
                            w = enter_stop(w, item.desired_speed_nonzero);
                            w.clr_tune = w.clr_tune || (state_reg.phase == PH_TUNE);
                        end
                    end
                    PH_STOP:
                    begin
                        // Release delay, DC braking, optional torque decay
                        if (w.st.release_cnt < brake_release_delay)
                            w.st.release_cnt = w.st.release_cnt + 1'b1;
                        else
                        begin
                            w.st.flags[F_BRAKE] = 1'b0;
                            if (w.st.dc_cnt < {1'b0, dc_brake_delay})
                                w.st.dc_cnt = w.st.dc_cnt + 1'b1;
                            else if (w.st.dc_cnt == {1'b0, dc_brake_delay})
                            begin
                                if (mode.closed_loop)
                                begin
                                    if (w.st.decay_cnt == '0)
                                    begin
                                        w.st.flags[F_DECAY] = 1'b1;
                                        w.st.decay_cnt      = w.st.decay_cnt + 1'b1;
                                    end
                                    else if (w.st.decay_cnt < torque_decay_time)
                                        w.st.decay_cnt = w.st.decay_cnt + 1'b1;
                                    else
                                    begin
                                        w = finish_stop(w);
                                        w.st.flags[F_DECAY] = 1'b0;
                                    end
                                end
                                else
                                    w = finish_stop(w);
                            end
                        end
                        if (item.ref_speed_nonzero)
                        begin
                            w.st.phase           = PH_CHECK;
                            w.reg_rst            = 1'b1;
                            w.st.flags[F_SCTEST] = 1'b1;
                        end
                    end
                    PH_TRIP:
                    begin
                        if (item.undervoltage)
                            w.st.flags[F_RELAY] = 1'b0;
                        if (!item.any_fault && !item.undervoltage && !mode.softcharge_hold)
                        begin
                            w.st.flags[F_RELAY] = 1'b1;
                            w = enter_stop(w, item.desired_speed_nonzero);
                        end
                    end
                    PH_CHECK:
                    begin
                        if (item.ref_speed_nonzero)
                        begin
                            w.st.flags[F_INHIBIT] = 1'b0;
                            if (item.short_check_done)
                            begin
                                w.st.flags[F_SCTEST] = 1'b0;
                                if (item.tune_requested)
                                    w = enter_tune(w, item.drive_enabled,
                                                   item.desired_speed_nonzero);
                                else
                                begin
                                    // Start: magnetise, hold brake, open it, go active
                                    w.link = LINK_CONNECT;
                                    if (item.motor_connected)
                                    begin
                                        w.st.flags[F_DECAY]   = 1'b0;
                                        w.st.flags[F_INHIBIT] = 1'b0;
                                        if (mode.pm_vector)
                                            w.st.flags[F_SERVO] = 1'b1;
                                        if (w.st.hold_cnt < brake_hold_delay)
                                            w.st.hold_cnt = w.st.hold_cnt + 1'b1;
                                        else
                                        begin
                                            w.ready = 1'b1;
                                            if (item.brake_open_allowed)
                                            begin
                                                w.st.flags[F_BRAKE] = 1'b1;
                                                if (w.st.move_cnt < {1'b0, motor_move_delay})
                                                    w.st.move_cnt = w.st.move_cnt + 1'b1;
                                                else if (w.st.move_cnt ==
                                                         {1'b0, motor_move_delay})
                                                begin
                                                    w.st.move_cnt = w.st.move_cnt + 1'b1;
                                                    w = enter_active(w, item.drive_enabled,
                                                                 item.desired_speed_nonzero);
                                                end
                                            end
                                        end
                                    end
                                end
                            end
                        end
                        else
                        begin
                            w.st.flags[F_SCTEST] = 1'b0;
                            w = enter_stop(w, item.desired_speed_nonzero);
                        end
                    end
                    default:
                    begin
                        w.st = w.st;
                    end
                endcase
            end
            OP_ESTOP:
            begin
                w.st.flags[F_INHIBIT] = 1'b1;
                w.st.flags[F_BRAKE]   = 1'b0;
                if (w.st.phase != PH_TRIP && w.st.phase != PH_STOP)
                    w = enter_stop(w, item.desired_speed_nonzero);
                w.st.flags[F_STOPPING] = 1'b0;
                w.st.flags[F_DECAY]    = 1'b0;
            end
            OP_TRIP:
            begin
                w.st.phase            = PH_TRIP;
                w.st.flags[F_INHIBIT] = 1'b1;
                w.st.flags[F_BRAKE]   = 1'b0;
                w.st.flags[F_DECAY]   = 1'b0;
                w.link                = LINK_DISCONNECT;
                w.reg_rst             = 1'b1;
            end
            default:
            begin
                w.st = state_reg;
            end
        endcase

        // Advance on a processed item; a softcharge hold write opens the relay
        state_next = step ? w.st : state_reg;
        if (relay_clr)
            state_next.flags[F_RELAY] = 1'b0;
    end

    // Hold state; advance it on each processed item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= {PH_NONE, {(ST_W - $bits(phase_t)){1'b0}}};
        else
            state_reg <= state_next;
    end

    // Result fields after this item
    always_comb
    begin
        res.drive_phase         = w.st.phase;
        res.brake_open          = w.st.flags[F_BRAKE];
        res.output_inhibit      = w.st.flags[F_INHIBIT];
        res.charge_relay_closed = w.st.flags[F_RELAY];
        res.stopping            = w.st.flags[F_STOPPING];
        res.torque_decay_on     = w.st.flags[F_DECAY];
        res.zero_servo_on       = w.st.flags[F_SERVO];
        res.short_test_active   = w.st.flags[F_SCTEST] && (w.st.phase == PH_CHECK);
        res.motor_link_cmd      = w.link;
        res.regulator_reset     = w.reg_rst;
        res.ready_for_brake     = w.ready;
        res.clear_tune_request  = w.clr_tune;
    end

endmodule

FILE: src/motor_drive_run_stop_sequencer.sv
// Top level of the motor drive run/stop sequencer: stream ports and staging.
//
// One control tick or event per input transfer; each produces exactly one
// result transfer. An item is held in the input register, is worked out
// against the phase and counter state in a single pass, and lands in the
// output register; a new item is taken every cycle while the result side
// keeps up. The phase/counter state update is the only loop. Configuration
// writes are taken at any time (cfg_ready is tied high) and should be made
// only while no item is in flight.
module motor_drive_run_stop_sequencer #(
    parameter int INIT_TICKS  = 3000,
    parameter int DELAY_WIDTH = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // tuser: op[1:0]
    // tdata: ref_speed_nonzero, desired_speed_nonzero, drive_enabled,
    //        motor_connected, brake_open_allowed, short_check_done,
    //        any_fault, undervoltage, tune_requested, zero fill [15:9]
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [15:0]                        s_tdata,
    input  logic [1:0]                         s_tuser,
    // tdata: drive_phase[2:0], brake_open, output_inhibit,
    //        charge_relay_closed, stopping, torque_decay_on, zero_servo_on,
    //        short_test_active, motor_link_cmd[11:10], regulator_reset,
    //        ready_for_brake, clear_tune_request, zero fill [15]
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [15:0]                        m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mdrs_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [DELAY_WIDTH-1:0]             cfg_data
);
    import mdrs_pkg::*;

    logic                   in_valid_reg;
    logic                   in_valid_next;
    item_t                  item_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    res_t                   res_reg;
    res_t                   res;
    logic                   s_xfer;
    logic                   advance;
    logic                   relay_clr;
    mode_t                  mode;
    logic [DELAY_WIDTH-1:0] dc_brake_delay;
    logic [DELAY_WIDTH-1:0] brake_release_delay;
    logic [DELAY_WIDTH-1:0] brake_hold_delay;
    logic [DELAY_WIDTH-1:0] motor_move_delay;
    logic [DELAY_WIDTH-1:0] torque_decay_time;

    // Handshake: process when the output register is free or being drained
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign s_xfer    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign in_valid_next  = s_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    // Control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture input item and result payloads
    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            item_reg.op                    <= s_tuser;
            item_reg.ref_speed_nonzero     <= s_tdata[0];
            item_reg.desired_speed_nonzero <= s_tdata[1];
            item_reg.drive_enabled         <= s_tdata[2];
            item_reg.motor_connected       <= s_tdata[3];
            item_reg.brake_open_allowed    <= s_tdata[4];
            item_reg.short_check_done      <= s_tdata[5];
            item_reg.any_fault             <= s_tdata[6];
            item_reg.undervoltage          <= s_tdata[7];
            item_reg.tune_requested        <= s_tdata[8];
        end
        if (advance)
            res_reg <= res;
    end

    mdrs_cfg #(
        .DELAY_WIDTH(DELAY_WIDTH)
    ) u_cfg (
        .clk                (clk),
        .rst_n              (rst_n),
        .wr_en              (cfg_valid && cfg_ready),
        .wr_index           (cfg_index),
        .wr_data            (cfg_data),
        .dc_brake_delay     (dc_brake_delay),
        .brake_release_delay(brake_release_delay),
        .brake_hold_delay   (brake_hold_delay),
        .motor_move_delay   (motor_move_delay),
        .torque_decay_time  (torque_decay_time),
        .mode               (mode),
        .relay_clr          (relay_clr)
    );

    mdrs_core #(
        .INIT_TICKS (INIT_TICKS),
        .DELAY_WIDTH(DELAY_WIDTH)
    ) u_core (
        .clk                (clk),
        .rst_n              (rst_n),
        .step               (advance),
        .item               (item_reg),
        .dc_brake_delay     (dc_brake_delay),
        .brake_release_delay(brake_release_delay),
        .brake_hold_delay   (brake_hold_delay),
        .motor_move_delay   (motor_move_delay),
        .torque_decay_time  (torque_decay_time),
        .mode               (mode),
        .relay_clr          (relay_clr),
        .res                (res)
    );

    // Pack the result transfer
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0,
                       res_reg.clear_tune_request,
                       res_reg.ready_for_brake,
                       res_reg.regulator_reset,
                       res_reg.motor_link_cmd,
                       res_reg.short_test_active,
                       res_reg.zero_servo_on,
                       res_reg.torque_decay_on,
                       res_reg.stopping,
                       res_reg.charge_relay_closed,
                       res_reg.output_inhibit,
                       res_reg.brake_open,
                       res_reg.drive_phase};

endmodule
